// ===== rtl/hdf_pkg.sv =====
// Shared types and constants for the hyperedge domination finder.
package hdf_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_EVAL  = 2'd3;

  localparam int SIZE_W      = 7;
  localparam int HITS_W      = 7;
  localparam int MAX_RESULTS = 64;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] node_id;
  } hdf_item_t;

  typedef struct packed {
    logic [5:0] edge_index;
    logic       found;
    logic       overflow;
    logic       last;
  } hdf_result_t;

endpackage

// ===== rtl/hdf_edge_store.sv =====
// Edge store: synchronous memory of node bitsets and sizes; read data is registered.
module hdf_edge_store #(
  parameter int NODE_COUNT    = 64,
  parameter int EDGE_CAPACITY = 64,
  localparam int IDX_W        = $clog2(EDGE_CAPACITY),
  localparam int DATA_W       = hdf_pkg::SIZE_W + NODE_COUNT
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [EDGE_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/hdf_scan.sv =====
// Evaluate sequencer: walks stored edge pairs through the edge store and emits results.
module hdf_scan #(
  parameter int NODE_COUNT    = 64,
  parameter int EDGE_CAPACITY = 64,
  localparam int IDX_W        = $clog2(EDGE_CAPACITY),
  localparam int CNT_W        = $clog2(EDGE_CAPACITY + 1),
  localparam int DATA_W       = hdf_pkg::SIZE_W + NODE_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [CNT_W-1:0]    count,
  input  logic                dropped,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [DATA_W-1:0]   rd_data,
  output logic                busy,
  output logic                strobe,
  output hdf_pkg::hdf_result_t result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDJ  = 3'd1;
  localparam logic [2:0] S_LDJ  = 3'd2;
  localparam logic [2:0] S_RDI  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                   state;
  logic [IDX_W-1:0]             j;
  logic [IDX_W-1:0]             i;
  logic [NODE_COUNT-1:0]        set_j;
  logic [hdf_pkg::SIZE_W-1:0]   size_j;
  logic                         pend;
  logic [IDX_W-1:0]             pend_idx;
  logic [hdf_pkg::HITS_W-1:0]   hits;

  logic [NODE_COUNT-1:0]        set_i;
  logic [hdf_pkg::SIZE_W-1:0]   size_i;
  logic                         subset;
  logic                         dom;
  logic                         hit;
  logic                         i_last;
  logic                         j_last;
  logic                         full;

  assign set_i  = rd_data[NODE_COUNT-1:0];
  assign size_i = rd_data[NODE_COUNT +: hdf_pkg::SIZE_W];
  assign subset = (set_i & ~set_j) == '0;

  always_comb begin
    if (size_i == size_j) begin
      dom = subset && (i < j);
    end else begin
      dom = subset && (size_i < size_j);
    end
  end

  assign hit    = (i != j) && dom;
  assign i_last = (CNT_W'(i) + CNT_W'(1)) == count;
  assign j_last = (CNT_W'(j) + CNT_W'(1)) == count;
  assign full   = (hits + hdf_pkg::HITS_W'(1)) == hdf_pkg::HITS_W'(hdf_pkg::MAX_RESULTS);

  assign rd_addr = (state == S_RDJ) ? j : i;
  assign busy    = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            j    <= '0;
            i    <= '0;
            pend <= 1'b0;
            hits <= '0;
            state <= (count == '0) ? S_FIN : S_RDJ;
          end
        end
        S_RDJ: begin
          state <= S_LDJ;
        end
        S_LDJ: begin
          set_j  <= rd_data[NODE_COUNT-1:0];
          size_j <= rd_data[NODE_COUNT +: hdf_pkg::SIZE_W];
          state  <= S_RDI;
        end
        S_RDI: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            hits     <= hits + hdf_pkg::HITS_W'(1);
            pend     <= 1'b1;
            pend_idx <= j;
            if (pend) begin
              strobe            <= 1'b1;
              result.edge_index <= 6'(pend_idx);
              result.found      <= 1'b1;
              result.overflow   <= dropped;
              result.last       <= 1'b0;
            end
          end
          if (hit || i_last) begin
            if (j_last || (hit && full)) begin
              state <= S_FIN;
            end else begin
              j     <= j + IDX_W'(1);
              i     <= '0;
              state <= S_RDJ;
            end
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_RDI;
          end
        end
        S_FIN: begin
          strobe            <= 1'b1;
          result.edge_index <= pend ? 6'(pend_idx) : 6'd0;
          result.found      <= pend;
          result.overflow   <= dropped;
          result.last       <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hyperedge_domination_finder_top.sv =====
// Top level of the hyperedge domination finder: command decode, edge building and store writes.
//
// Usage: a command transfer happens at a rising edge where start is high and busy is
// low; request carries cmd and node_id. Clear, add node and close produce no result,
// so such commands may follow one another every cycle. Evaluate raises busy from the
// next cycle on. It compares each stored edge j against stored edges i, one memory
// read per comparison on the single read port of the edge store: for each edge j the
// scan reads and loads edge j, then reads and compares edges i in turn until one
// dominates j or all have been examined, and a closing step ends the run, which is
// all that runs when the store is empty. Results appear on result for one cycle each,
// marked by strobe, in ascending edge order; the last one has result.last set and is
// given in the same cycle in which busy falls. When nothing is dominated a single result
// with found low is given. The receiver cannot stall: every strobed result is taken.
// Reset (rst, synchronous) empties the store count, the building edge and the overflow
// flag; stored entries are never read beyond the count and need no clearing pass.
module hyperedge_domination_finder_top #(
  parameter int NODE_COUNT    = 64,
  parameter int EDGE_CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  hdf_pkg::hdf_item_t   request,
  output logic                 strobe,
  output hdf_pkg::hdf_result_t result
);

  localparam int IDX_W  = $clog2(EDGE_CAPACITY);
  localparam int CNT_W  = $clog2(EDGE_CAPACITY + 1);
  localparam int NW     = $clog2(NODE_COUNT);
  localparam int DATA_W = hdf_pkg::SIZE_W + NODE_COUNT;

  logic [NODE_COUNT-1:0]      building;
  logic [hdf_pkg::SIZE_W-1:0] bsize;
  logic [CNT_W-1:0]           count;
  logic                       dropped;

  logic                       accept;
  logic                       in_range;
  logic                       room;
  logic                       wr_en;
  logic                       go;
  logic [IDX_W-1:0]           rd_addr;
  logic [DATA_W-1:0]          rd_data;

  assign accept   = start && !busy;
  assign in_range = {1'b0, request.node_id} < 7'(NODE_COUNT);
  assign room     = count < CNT_W'(EDGE_CAPACITY);
  assign wr_en    = accept && (request.cmd == hdf_pkg::CMD_CLOSE) && room;
  assign go       = accept && (request.cmd == hdf_pkg::CMD_EVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      building <= '0;
      bsize    <= '0;
      count    <= '0;
      dropped  <= 1'b0;
    end else if (accept) begin
      unique case (request.cmd)
        hdf_pkg::CMD_CLEAR: begin
          building <= '0;
          bsize    <= '0;
          count    <= '0;
          dropped  <= 1'b0;
        end
        hdf_pkg::CMD_ADD: begin
          if (in_range && !building[request.node_id[NW-1:0]]) begin
            building[request.node_id[NW-1:0]] <= 1'b1;
            bsize <= bsize + hdf_pkg::SIZE_W'(1);
          end
        end
        hdf_pkg::CMD_CLOSE: begin
          if (room) begin
            count <= count + CNT_W'(1);
          end else begin
            dropped <= 1'b1;
          end
          building <= '0;
          bsize    <= '0;
        end
        hdf_pkg::CMD_EVAL: begin
        end
        default: begin
        end
      endcase
    end
  end

  hdf_edge_store #(
    .NODE_COUNT    (NODE_COUNT),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data ({bsize, building}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hdf_scan #(
    .NODE_COUNT    (NODE_COUNT),
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .count   (count),
    .dropped (dropped),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

// ===== sim/hyperedge_domination_finder_top_test.sv =====
// Self-checking testbench for the hyperedge domination finder top level.
`timescale 1ns / 100ps

module hyperedge_domination_finder_top_test;

  localparam int NODES    = 64;
  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 200;

  logic                 clk;
  logic                 rst;
  logic                 start = 1'b0;
  logic                 busy;
  hdf_pkg::hdf_item_t   request = '0;
  logic                 strobe;
  hdf_pkg::hdf_result_t result;

  hdf_pkg::hdf_item_t   command_queue[$];
  hdf_pkg::hdf_result_t dominated_reports[$];
  int          queued_items = 0;
  int          accepted_items = 0;
  int          error_count = 0;

  logic [63:0] stored_sets[CAPACITY];
  int          stored_sizes[CAPACITY];
  int          stored_count = 0;
  logic [63:0] building_nodes = '0;
  logic        dropped = 1'b0;

  hyperedge_domination_finder_top #(
    .NODE_COUNT(NODES),
    .EDGE_CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int node_total(logic [63:0] nodes);
    int total;
    total = 0;
    for (int k = 0; k < 64; k++) total += nodes[k];
    return total;
  endfunction

  task automatic queue_command(logic [1:0] cmd, logic [5:0] node_id);
    hdf_pkg::hdf_item_t item;
    item.cmd = cmd;
    item.node_id = node_id;
    command_queue.insert(command_queue.size(), item);
    queued_items++;
  endtask

  task automatic predict_command(hdf_pkg::hdf_item_t item);
    int                   hits;
    bit                   dominated;
    hdf_pkg::hdf_result_t report;
    unique case (item.cmd)
      hdf_pkg::CMD_CLEAR: begin
        stored_count = 0;
        building_nodes = '0;
        dropped = 1'b0;
      end
      hdf_pkg::CMD_ADD: begin
        if (item.node_id < NODES) building_nodes[item.node_id] = 1'b1;
      end
      hdf_pkg::CMD_CLOSE: begin
        if (stored_count < CAPACITY) begin
          stored_sets[stored_count] = building_nodes;
          stored_sizes[stored_count] = node_total(building_nodes);
          stored_count++;
        end else begin
          dropped = 1'b1;
        end
        building_nodes = '0;
      end
      default: begin
        hits = 0;
        for (int j = 0; j < stored_count && hits < hdf_pkg::MAX_RESULTS; j++) begin
          dominated = 1'b0;
          for (int i = 0; i < stored_count && !dominated; i++) begin
            if (i != j && (stored_sets[i] & ~stored_sets[j]) == '0) begin
              if (stored_sizes[i] == stored_sizes[j]) dominated = (i < j);
              else dominated = (stored_sizes[i] < stored_sizes[j]);
            end
          end
          if (dominated) begin
            report = '{edge_index: 6'(j), found: 1'b1, overflow: dropped, last: 1'b0};
            dominated_reports.insert(dominated_reports.size(), report);
            hits++;
          end
        end
        if (hits == 0) begin
          report = '{edge_index: 6'd0, found: 1'b0, overflow: dropped, last: 1'b1};
          dominated_reports.insert(dominated_reports.size(), report);
        end else begin
          dominated_reports[dominated_reports.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
    end else begin
      if (start && !busy) begin
        predict_command(request);
        accepted_items++;
      end
      if (!start || !busy) begin
        if (command_queue.size() != 0 &&
            ((accepted_items > 80 && accepted_items < 160) || $urandom_range(99) >= 22)) begin
          request <= command_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    hdf_pkg::hdf_result_t want;
    if (!rst && strobe) begin
      if (dominated_reports.size() == 0) begin
        $display("%0t: unexpected result, got index %0d found %0d overflow %0d last %0d",
                 $time, result.edge_index, result.found, result.overflow, result.last);
        error_count++;
      end else begin
        want = dominated_reports.pop_front();
        if (result.edge_index !== want.edge_index)
          report_mismatch("edge_index", 8'(want.edge_index), 8'(result.edge_index));
        if (result.found !== want.found)
          report_mismatch("found", 8'(want.found), 8'(result.found));
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", 8'(want.overflow), 8'(result.overflow));
        if (result.last !== want.last)
          report_mismatch("last", 8'(want.last), 8'(result.last));
      end
    end
  end

  task automatic build_directed();
    queue_command(hdf_pkg::CMD_EVAL, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd63);
    queue_command(hdf_pkg::CMD_ADD, 6'd63);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd42);
    queue_command(hdf_pkg::CMD_ADD, 6'd21);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_EVAL, 6'd0);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd0);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd0);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_ADD, 6'd5);
    queue_command(hdf_pkg::CMD_EVAL, 6'd0);
    queue_command(hdf_pkg::CMD_CLOSE, 6'd0);
    queue_command(hdf_pkg::CMD_EVAL, 6'd0);
    queue_command(hdf_pkg::CMD_CLEAR, 6'd0);
    queue_command(hdf_pkg::CMD_EVAL, 6'd0);
  endtask

  task automatic build_random();
    int  target;
    int  edge_total;
    int  node_span;
    bit  fill_store;
    target = queued_items + RANDOM_ITEMS;
    for (int phase = 0; queued_items < target; phase++) begin
      fill_store = (phase == 0);
      edge_total = fill_store ? CAPACITY + 2 + $urandom_range(2) : $urandom_range(10, 1);
      node_span = fill_store ? 2 : 5;
      if ($urandom_range(3) != 0) queue_command(hdf_pkg::CMD_CLEAR, 6'($urandom_range(63)));
      for (int e = 0; e < edge_total; e++) begin
        repeat ($urandom_range(node_span)) begin
          if ($urandom_range(3) == 0) queue_command(hdf_pkg::CMD_ADD, 6'($urandom_range(63)));
          else queue_command(hdf_pkg::CMD_ADD, 6'($urandom_range(7)));
        end
        if ($urandom_range(11) == 0)
          queue_command(2'($urandom_range(3)), 6'($urandom_range(63)));
        queue_command(hdf_pkg::CMD_CLOSE, 6'($urandom_range(63)));
      end
      if ($urandom_range(2) == 0) queue_command(hdf_pkg::CMD_ADD, 6'($urandom_range(63)));
      queue_command(hdf_pkg::CMD_EVAL, 6'($urandom_range(63)));
    end
  endtask

  initial begin
    rst = 1'b1;
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (command_queue.size() != 0 || start || dominated_reports.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("hyperedge_domination_finder_top_test: clean");
    end else begin
      $display("hyperedge_domination_finder_top_test: errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("hyperedge_domination_finder_top_test: errors");
    $finish;
  end

endmodule
